### sv/dcpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-chamber pacing timer package
// Shared widths, codes, configuration and result types for the pacing timer.
// ----------------------------------------------------------------------------
package dcpt_pkg;

    // Width of the two millisecond timers.
    localparam int TIMER_BITS = 14;

    // Configuration register widths.
    localparam int RATE_BITS  = 13;
    localparam int DELAY_BITS = 10;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = RATE_BITS;

    // Compare width: wide enough for a timer plus a delay, or any rate interval.
    localparam int CMP_BITS = ((TIMER_BITS > RATE_BITS) ? TIMER_BITS : RATE_BITS) + 1;

    // Fixed refractory window in ms.
    localparam int REFRACTORY_MS = 500;

    // Operation codes; codes six and seven are unused.
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_A_SENSE  = 3'd1,
        OP_V_SENSE  = 3'd2,
        OP_MODE_REQ = 3'd3,
        OP_MAN_AP   = 3'd4,
        OP_MAN_VP   = 3'd5
    } t_op;

    // Pacing modes.
    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_SLEEP    = 2'd1,
        MODE_EXERCISE = 2'd2,
        MODE_MANUAL   = 2'd3
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOWER_NORMAL   = 4'd0,
        CFG_LOWER_SLEEP    = 4'd1,
        CFG_LOWER_EXERCISE = 4'd2,
        CFG_UPPER_NORMAL   = 4'd3,
        CFG_UPPER_SLEEP    = 4'd4,
        CFG_UPPER_EXERCISE = 4'd5,
        CFG_AV_DELAY_MAX   = 4'd6,
        CFG_AV_DELAY_MIN   = 4'd7
    } t_cfg_idx;

    // Register reset values.
    localparam logic [RATE_BITS-1:0]  RST_LOWER_NORMAL   = 13'd2000;
    localparam logic [RATE_BITS-1:0]  RST_LOWER_SLEEP    = 13'd1500;
    localparam logic [RATE_BITS-1:0]  RST_LOWER_EXERCISE = 13'd600;
    localparam logic [RATE_BITS-1:0]  RST_UPPER_NORMAL   = 13'd1000;
    localparam logic [RATE_BITS-1:0]  RST_UPPER_SLEEP    = 13'd600;
    localparam logic [RATE_BITS-1:0]  RST_UPPER_EXERCISE = 13'd343;
    localparam logic [DELAY_BITS-1:0] RST_AV_DELAY_MAX   = 10'd100;
    localparam logic [DELAY_BITS-1:0] RST_AV_DELAY_MIN   = 10'd30;

    // Configuration bundle handed to the timing core.
    typedef struct packed {
        logic [RATE_BITS-1:0]  lower_normal;
        logic [RATE_BITS-1:0]  lower_sleep;
        logic [RATE_BITS-1:0]  lower_exercise;
        logic [RATE_BITS-1:0]  upper_normal;
        logic [RATE_BITS-1:0]  upper_sleep;
        logic [RATE_BITS-1:0]  upper_exercise;
        logic [DELAY_BITS-1:0] av_delay_max;
        logic [DELAY_BITS-1:0] av_delay_min;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic       atrial_pace;
        logic       ventricular_pace;
        logic [1:0] current_mode;
        logic       expect_ventricle;
    } t_result;

endpackage

### sv/dual_chamber_pacing_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-chamber pacing timer
// Event-driven atrial and ventricular pacing with per-mode rate limits.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------
//  input    | i_in_valid / o_in_stall    | i_operation, i_requested_mode
//  result   | o_out_valid / i_out_stall  | o_atrial_pace, o_ventricular_pace,
//           |                            | o_current_mode, o_expect_ventricle
//  config   | i_cfg_wr_en                | i_cfg_index, i_cfg_wdata
//
// One event is taken per cycle while o_in_stall is low; its result is
// registered in the output buffer's result register, or in its skid entry.
// Synchronous active-low reset restores the register defaults, normal mode,
// cleared timers and an empty result buffer.
// A result stall is absorbed by one skid entry; the input stalls only while
// that entry is occupied.
// ----------------------------------------------------------------------------
module dual_chamber_pacing_timer
    import dcpt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_operation,
    input  logic [1:0]               i_requested_mode,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_atrial_pace,
    output logic                     o_ventricular_pace,
    output logic [1:0]               o_current_mode,
    output logic                     o_expect_ventricle,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    buf_full;
    logic    in_fire;

    // An input transfer completes whenever the skid entry is free.
    assign o_in_stall = buf_full;
    assign in_fire    = i_in_valid && !buf_full;

    dcpt_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dcpt_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (in_fire),
        .i_operation      (i_operation),
        .i_requested_mode (i_requested_mode),
        .i_cfg            (cfg),
        .o_result         (core_result)
    );

    dcpt_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_fire),
        .i_data      (core_result),
        .i_out_stall (i_out_stall),
        .o_full      (buf_full),
        .o_valid     (o_out_valid),
        .o_data      (out_result)
    );

    assign o_atrial_pace      = out_result.atrial_pace;
    assign o_ventricular_pace = out_result.ventricular_pace;
    assign o_current_mode     = out_result.current_mode;
    assign o_expect_ventricle = out_result.expect_ventricle;

endmodule

### sv/dcpt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pacing timer configuration registers
// Holds the rate intervals and AV delay limits written through the plain port.
// ----------------------------------------------------------------------------
module dcpt_cfg_regs
    import dcpt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; data is truncated to the register width and
    // indexes beyond the list are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOWER_NORMAL:   n_cfg.lower_normal   = i_cfg_wdata[RATE_BITS-1:0];
                CFG_LOWER_SLEEP:    n_cfg.lower_sleep    = i_cfg_wdata[RATE_BITS-1:0];
                CFG_LOWER_EXERCISE: n_cfg.lower_exercise = i_cfg_wdata[RATE_BITS-1:0];
                CFG_UPPER_NORMAL:   n_cfg.upper_normal   = i_cfg_wdata[RATE_BITS-1:0];
                CFG_UPPER_SLEEP:    n_cfg.upper_sleep    = i_cfg_wdata[RATE_BITS-1:0];
                CFG_UPPER_EXERCISE: n_cfg.upper_exercise = i_cfg_wdata[RATE_BITS-1:0];
                CFG_AV_DELAY_MAX:   n_cfg.av_delay_max   = i_cfg_wdata[DELAY_BITS-1:0];
                CFG_AV_DELAY_MIN:   n_cfg.av_delay_min   = i_cfg_wdata[DELAY_BITS-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // Register bank with its documented reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_normal   <= RST_LOWER_NORMAL;
            r_cfg.lower_sleep    <= RST_LOWER_SLEEP;
            r_cfg.lower_exercise <= RST_LOWER_EXERCISE;
            r_cfg.upper_normal   <= RST_UPPER_NORMAL;
            r_cfg.upper_sleep    <= RST_UPPER_SLEEP;
            r_cfg.upper_exercise <= RST_UPPER_EXERCISE;
            r_cfg.av_delay_max   <= RST_AV_DELAY_MAX;
            r_cfg.av_delay_min   <= RST_AV_DELAY_MIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/dcpt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pacing timer core
// Holds mode, expectation flag and both timers; works out one event per cycle.
// ----------------------------------------------------------------------------
module dcpt_core
    import dcpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [2:0] i_operation,
    input  logic [1:0] i_requested_mode,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    t_mode                 r_mode,  n_mode;
    logic                  r_vnext, n_vnext;
    logic [TIMER_BITS-1:0] r_ael,   n_ael;
    logic [TIMER_BITS-1:0] r_vel,   n_vel;

    logic                  manual;
    logic [TIMER_BITS-1:0] ael_inc;
    logic [TIMER_BITS-1:0] vel_inc;
    logic [RATE_BITS-1:0]  lri;
    logic [RATE_BITS-1:0]  uri;
    logic [CMP_BITS-1:0]   vel_cmp;
    logic                  apace;
    logic                  vpace;

    assign manual = (r_mode == MODE_MANUAL);

    // Saturating increments for the tick.
    assign ael_inc = (r_ael == TIMER_MAX) ? r_ael : r_ael + 1'b1;
    assign vel_inc = (r_vel == TIMER_MAX) ? r_vel : r_vel + 1'b1;
    assign vel_cmp = CMP_BITS'(r_vel);

    // Rate intervals of the current mode; manual falls back to normal.
    always_comb begin
        case (r_mode)
            MODE_SLEEP: begin
                lri = i_cfg.lower_sleep;
                uri = i_cfg.upper_sleep;
            end
            MODE_EXERCISE: begin
                lri = i_cfg.lower_exercise;
                uri = i_cfg.upper_exercise;
            end
            default: begin
                lri = i_cfg.lower_normal;
                uri = i_cfg.upper_normal;
            end
        endcase
    end

    // Event decode and next state.
    always_comb begin
        n_mode  = r_mode;
        n_vnext = r_vnext;
        n_ael   = r_ael;
        n_vel   = r_vel;
        apace   = 1'b0;
        vpace   = 1'b0;
        case (t_op'(i_operation))
            OP_TICK: begin
                n_ael = ael_inc;
                n_vel = vel_inc;
                if (!manual) begin
                    if (r_vnext) begin
                        if (CMP_BITS'(vel_inc) >= CMP_BITS'(lri) ||
                            CMP_BITS'(ael_inc) >= CMP_BITS'(i_cfg.av_delay_max)) begin
                            vpace   = 1'b1;
                            n_vel   = '0;
                            n_vnext = 1'b0;
                        end
                    end else if (CMP_BITS'(vel_inc) + CMP_BITS'(i_cfg.av_delay_min)
                                 >= CMP_BITS'(lri)) begin
                        apace   = 1'b1;
                        n_ael   = '0;
                        n_vnext = 1'b1;
                    end
                end
            end
            OP_A_SENSE: begin
                if (!manual && !r_vnext && vel_cmp >= CMP_BITS'(REFRACTORY_MS)) begin
                    n_ael   = '0;
                    n_vnext = 1'b1;
                end
            end
            OP_V_SENSE: begin
                if (!manual && r_vnext &&
                    vel_cmp >= CMP_BITS'(uri) &&
                    vel_cmp >= CMP_BITS'(REFRACTORY_MS) &&
                    vel_cmp >= CMP_BITS'(i_cfg.av_delay_min)) begin
                    n_vel   = '0;
                    n_vnext = 1'b0;
                end
            end
            OP_MODE_REQ: begin
                if (!(manual && t_mode'(i_requested_mode) == MODE_MANUAL)) begin
                    n_mode = t_mode'(i_requested_mode);
                end
            end
            OP_MAN_AP: begin
                if (manual) begin
                    apace   = 1'b1;
                    n_ael   = '0;
                    n_vnext = 1'b1;
                end
            end
            OP_MAN_VP: begin
                if (manual) begin
                    vpace   = 1'b1;
                    n_vel   = '0;
                    n_vnext = 1'b0;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // State advances only on an accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_vnext <= 1'b0;
            r_ael   <= '0;
            r_vel   <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_vnext <= n_vnext;
            r_ael   <= n_ael;
            r_vel   <= n_vel;
        end
    end

    // Result as seen after this event.
    assign o_result.atrial_pace      = apace;
    assign o_result.ventricular_pace = vpace;
    assign o_result.current_mode     = n_mode;
    assign o_result.expect_ventricle = n_vnext;

`ifndef SYNTHESIS
    // Only one chamber is paced by any single event.
    a_one_pace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(apace && vpace))
        else $error("atrial and ventricular pace from one event");

    // A manual ventricular pace in manual mode restarts the ventricular timer.
    a_man_vp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_operation == OP_MAN_VP && r_mode == MODE_MANUAL)
        |=> (r_vel == '0 && !r_vnext))
        else $error("manual ventricular pace did not restart the timer");

    // In manual mode ticks and senses leave mode and expectation untouched.
    a_manual_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_mode == MODE_MANUAL &&
         (i_operation == OP_TICK || i_operation == OP_A_SENSE ||
          i_operation == OP_V_SENSE))
        |=> ($stable(r_vnext) && $stable(r_mode)))
        else $error("manual mode state changed by tick or sense");

    // Outside manual mode a mode request is always taken.
    a_mode_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_operation == OP_MODE_REQ && r_mode != MODE_MANUAL)
        |=> (r_mode == $past(i_requested_mode)))
        else $error("mode request not taken");
`endif

endmodule

### sv/dcpt_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pacing timer result buffer
// Result register with a skid stage, so one more input transfer is taken
// while the output is stalled.
// ----------------------------------------------------------------------------
module dcpt_out_buf
    import dcpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_out_stall,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main,       n_main;
    t_result r_skid,       n_skid;
    logic    pop;

    assign pop = r_main_valid && !i_out_stall;

    // Push is only offered while the skid stage is empty.
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop && r_skid_valid) begin
            n_main       = r_skid;
            n_skid_valid = 1'b0;
        end else if (i_push && (!r_main_valid || pop)) begin
            n_main       = i_data;
            n_main_valid = 1'b1;
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end else if (pop) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

### bench/dual_chamber_pacing_timer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-chamber pacing timer testbench
// Drives tick, sense, mode and manual pace events through the valid/stall
// input channel and checks every result transfer against a cycle-free model
// of the pacing rules, or typed-in results on marked rows. A short directed
// table comes first, then random phases under several interval settings and
// idling patterns, a back-pressure phase and a run of ticks in manual mode.
// ----------------------------------------------------------------------------
module dual_chamber_pacing_timer_tb;
    import dcpt_pkg::*;

    // Operation codes the block leaves unused, and register indexes it ignores.
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LOW  = 4'd8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HIGH = 4'd15;

    localparam logic [TIMER_BITS-1:0] TIMER_FULL = '1;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 2;
    localparam int TAIL_CYCLES   = 10;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int LONG_HOLD     = 60;
    localparam int MANUAL_TICKS  = 50;
    localparam int REPORT_LINES  = 200;
    localparam int TIMEOUT_NS    = 4_000_000;

    // Clock, reset and block ports; every input starts at a known value.
    logic                     i_clk;
    logic                     i_rst_n          = 1'b0;
    logic                     i_in_valid       = 1'b0;
    logic                     o_in_stall;
    logic [2:0]               i_operation      = '0;
    logic [1:0]               i_requested_mode = '0;
    logic                     o_out_valid;
    logic                     i_out_stall      = 1'b0;
    logic                     o_atrial_pace;
    logic                     o_ventricular_pace;
    logic [1:0]               o_current_mode;
    logic                     o_expect_ventricle;
    logic                     i_cfg_wr_en      = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata      = '0;

    dual_chamber_pacing_timer u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_requested_mode   (i_requested_mode),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_atrial_pace      (o_atrial_pace),
        .o_ventricular_pace (o_ventricular_pace),
        .o_current_mode     (o_current_mode),
        .o_expect_ventricle (o_expect_ventricle),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    // Idling knobs, set per phase by the stimulus process.
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int          hold_left      = 0;
    int          mismatch_count = 0;

    // Expected results, oldest first.
    t_result pace_results_due[$];

    // Model copy of the interval registers.
    logic [RATE_BITS-1:0]  lri_normal, lri_sleep, lri_exercise;
    logic [RATE_BITS-1:0]  uri_normal, uri_sleep, uri_exercise;
    logic [DELAY_BITS-1:0] av_max_ms, av_min_ms;

    // Model copy of the pacing state.
    t_mode                 model_mode;
    logic                  ventricle_due;
    logic [TIMER_BITS-1:0] atrial_ms, ventricular_ms;

    // Directed stimulus: the expected result is typed in only on marked rows.
    typedef struct packed {
        logic [2:0] op;
        logic [1:0] req;
        logic       typed;
        t_result    want;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 24;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{OP_TICK,     MODE_NORMAL,   1'b1, '{1'b0, 1'b0, MODE_NORMAL,   1'b0}},
        '{OP_UNUSED_6, MODE_MANUAL,   1'b1, '{1'b0, 1'b0, MODE_NORMAL,   1'b0}},
        '{OP_UNUSED_7, MODE_NORMAL,   1'b1, '{1'b0, 1'b0, MODE_NORMAL,   1'b0}},
        '{OP_A_SENSE,  MODE_SLEEP,    1'b1, '{1'b0, 1'b0, MODE_NORMAL,   1'b0}},
        '{OP_V_SENSE,  MODE_EXERCISE, 1'b1, '{1'b0, 1'b0, MODE_NORMAL,   1'b0}},
        '{OP_MAN_AP,   MODE_MANUAL,   1'b1, '{1'b0, 1'b0, MODE_NORMAL,   1'b0}},
        '{OP_MAN_VP,   MODE_MANUAL,   1'b1, '{1'b0, 1'b0, MODE_NORMAL,   1'b0}},
        '{OP_MODE_REQ, MODE_SLEEP,    1'b1, '{1'b0, 1'b0, MODE_SLEEP,    1'b0}},
        '{OP_MODE_REQ, MODE_EXERCISE, 1'b1, '{1'b0, 1'b0, MODE_EXERCISE, 1'b0}},
        '{OP_MODE_REQ, MODE_MANUAL,   1'b1, '{1'b0, 1'b0, MODE_MANUAL,   1'b0}},
        '{OP_MODE_REQ, MODE_MANUAL,   1'b1, '{1'b0, 1'b0, MODE_MANUAL,   1'b0}},
        '{OP_MAN_AP,   MODE_NORMAL,   1'b1, '{1'b1, 1'b0, MODE_MANUAL,   1'b1}},
        '{OP_A_SENSE,  MODE_NORMAL,   1'b1, '{1'b0, 1'b0, MODE_MANUAL,   1'b1}},
        '{OP_MAN_VP,   MODE_SLEEP,    1'b1, '{1'b0, 1'b1, MODE_MANUAL,   1'b0}},
        '{OP_V_SENSE,  MODE_NORMAL,   1'b1, '{1'b0, 1'b0, MODE_MANUAL,   1'b0}},
        '{OP_TICK,     MODE_MANUAL,   1'b1, '{1'b0, 1'b0, MODE_MANUAL,   1'b0}},
        '{OP_UNUSED_6, MODE_SLEEP,    1'b1, '{1'b0, 1'b0, MODE_MANUAL,   1'b0}},
        '{OP_MODE_REQ, MODE_SLEEP,    1'b1, '{1'b0, 1'b0, MODE_SLEEP,    1'b0}},
        '{OP_TICK,     MODE_EXERCISE, 1'b0, '0},
        '{OP_MODE_REQ, MODE_NORMAL,   1'b0, '0},
        '{OP_MAN_AP,   MODE_MANUAL,   1'b0, '0},
        '{OP_TICK,     MODE_NORMAL,   1'b0, '0},
        '{OP_MODE_REQ, MODE_EXERCISE, 1'b0, '0},
        '{OP_TICK,     MODE_SLEEP,    1'b0, '0}
    };

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Lower and upper rate intervals of the current mode.
    function automatic logic [RATE_BITS-1:0] lower_interval();
        case (model_mode)
            MODE_SLEEP:    return lri_sleep;
            MODE_EXERCISE: return lri_exercise;
            default:       return lri_normal;
        endcase
    endfunction

    function automatic logic [RATE_BITS-1:0] upper_interval();
        case (model_mode)
            MODE_SLEEP:    return uri_sleep;
            MODE_EXERCISE: return uri_exercise;
            default:       return uri_normal;
        endcase
    endfunction

    // Register write as the block sees it: masked to width, spare indexes ignored.
    function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            CFG_LOWER_NORMAL:   lri_normal   = value[RATE_BITS-1:0];
            CFG_LOWER_SLEEP:    lri_sleep    = value[RATE_BITS-1:0];
            CFG_LOWER_EXERCISE: lri_exercise = value[RATE_BITS-1:0];
            CFG_UPPER_NORMAL:   uri_normal   = value[RATE_BITS-1:0];
            CFG_UPPER_SLEEP:    uri_sleep    = value[RATE_BITS-1:0];
            CFG_UPPER_EXERCISE: uri_exercise = value[RATE_BITS-1:0];
            CFG_AV_DELAY_MAX:   av_max_ms    = value[DELAY_BITS-1:0];
            CFG_AV_DELAY_MIN:   av_min_ms    = value[DELAY_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Next pacing state and the result of one event.
    function automatic t_result pacer_step(input logic [2:0] op, input logic [1:0] req);
        t_result     res;
        logic        manual;
        logic [31:0] a_now, v_now, lri;
        res    = '0;
        manual = (model_mode == MODE_MANUAL);
        case (op)
            OP_TICK: begin
                if (atrial_ms != TIMER_FULL) atrial_ms = atrial_ms + 1'b1;
                if (ventricular_ms != TIMER_FULL) ventricular_ms = ventricular_ms + 1'b1;
                a_now = 32'(atrial_ms);
                v_now = 32'(ventricular_ms);
                lri   = 32'(lower_interval());
                if (!manual) begin
                    if (ventricle_due) begin
                        if (v_now >= lri || a_now >= av_max_ms) begin
                            res.ventricular_pace = 1'b1;
                            ventricular_ms = '0;
                            ventricle_due  = 1'b0;
                        end
                    end else if (v_now + av_min_ms >= lri) begin
                        res.atrial_pace = 1'b1;
                        atrial_ms     = '0;
                        ventricle_due = 1'b1;
                    end
                end
            end
            OP_A_SENSE: begin
                v_now = 32'(ventricular_ms);
                if (!manual && !ventricle_due && v_now >= REFRACTORY_MS) begin
                    atrial_ms     = '0;
                    ventricle_due = 1'b1;
                end
            end
            OP_V_SENSE: begin
                v_now = 32'(ventricular_ms);
                if (!manual && ventricle_due && v_now >= upper_interval() &&
                    v_now >= REFRACTORY_MS && v_now >= av_min_ms) begin
                    ventricular_ms = '0;
                    ventricle_due  = 1'b0;
                end
            end
            OP_MODE_REQ: begin
                if (!(manual && req == MODE_MANUAL)) model_mode = t_mode'(req);
            end
            OP_MAN_AP: begin
                if (manual) begin
                    res.atrial_pace = 1'b1;
                    atrial_ms     = '0;
                    ventricle_due = 1'b1;
                end
            end
            OP_MAN_VP: begin
                if (manual) begin
                    res.ventricular_pace = 1'b1;
                    ventricular_ms = '0;
                    ventricle_due  = 1'b0;
                end
            end
            default: ;
        endcase
        res.current_mode     = model_mode;
        res.expect_ventricle = ventricle_due;
        return res;
    endfunction

    // One line per mismatch, with the printing capped for badly broken runs.
    task automatic report_mismatch(input string what, input logic [1:0] got,
                                   input logic [1:0] want);
        if (mismatch_count < REPORT_LINES)
            $display("ERROR %0t: %s got %b expected %b", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one event, hold it until the transfer, then record what it must give.
    task automatic send_event(input logic [2:0] op, input logic [1:0] req,
                              input logic typed, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_requested_mode <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = pacer_step(op, req);
        pace_results_due.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected result has been taken.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pace_results_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write; the block is idle whenever this is called.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        apply_register(idx, value);
        @(negedge i_clk);
    endtask

    task automatic load_intervals(input logic [CFG_DATA_BITS-1:0] ln, ls, le, un, us, ue,
                                  input logic [CFG_DATA_BITS-1:0] av_max, av_min);
        write_reg(CFG_LOWER_NORMAL, ln);
        write_reg(CFG_LOWER_SLEEP, ls);
        write_reg(CFG_LOWER_EXERCISE, le);
        write_reg(CFG_UPPER_NORMAL, un);
        write_reg(CFG_UPPER_SLEEP, us);
        write_reg(CFG_UPPER_EXERCISE, ue);
        write_reg(CFG_AV_DELAY_MAX, av_max);
        write_reg(CFG_AV_DELAY_MIN, av_min);
    endtask

    task automatic load_random_intervals();
        load_intervals(CFG_DATA_BITS'($urandom_range(1, 1200)),
                       CFG_DATA_BITS'($urandom_range(1, 1200)),
                       CFG_DATA_BITS'($urandom_range(1, 1200)),
                       CFG_DATA_BITS'($urandom_range(1, 800)),
                       CFG_DATA_BITS'($urandom_range(1, 800)),
                       CFG_DATA_BITS'($urandom_range(1, 800)),
                       CFG_DATA_BITS'($urandom_range(1, 1023)),
                       CFG_DATA_BITS'($urandom_range(0, 1023)));
    endtask

    // Mostly runs of ticks with senses, mode changes and manual paces between.
    task automatic run_random_events(input int count, input int tick_pct);
        logic [2:0] op;
        int         pick;
        repeat (count) begin
            if ($urandom_range(99) < tick_pct) begin
                op = OP_TICK;
            end else begin
                pick = $urandom_range(15);
                if (pick < 4)       op = OP_A_SENSE;
                else if (pick < 8)  op = OP_V_SENSE;
                else if (pick < 11) op = OP_MODE_REQ;
                else if (pick < 13) op = OP_MAN_AP;
                else if (pick < 15) op = OP_MAN_VP;
                else                op = ($urandom_range(1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
            end
            send_event(op, 2'($urandom_range(3)), 1'b0, '0);
        end
    endtask

    // Receiver stall: random per phase, or a long hold when one is requested.
    always @(negedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result check on every result transfer.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pace_results_due.size() == 0) begin
                report_mismatch("result with nothing outstanding", 2'b0, 2'b0);
            end else begin
                want = pace_results_due.pop_front();
                if (o_atrial_pace !== want.atrial_pace)
                    report_mismatch("atrial_pace", 2'(o_atrial_pace),
                                    2'(want.atrial_pace));
                if (o_ventricular_pace !== want.ventricular_pace)
                    report_mismatch("ventricular_pace", 2'(o_ventricular_pace),
                                    2'(want.ventricular_pace));
                if (o_current_mode !== want.current_mode)
                    report_mismatch("current_mode", o_current_mode, want.current_mode);
                if (o_expect_ventricle !== want.expect_ventricle)
                    report_mismatch("expect_ventricle", 2'(o_expect_ventricle),
                                    2'(want.expect_ventricle));
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int drain_cycles;

        lri_normal     = RST_LOWER_NORMAL;
        lri_sleep      = RST_LOWER_SLEEP;
        lri_exercise   = RST_LOWER_EXERCISE;
        uri_normal     = RST_UPPER_NORMAL;
        uri_sleep      = RST_UPPER_SLEEP;
        uri_exercise   = RST_UPPER_EXERCISE;
        av_max_ms      = RST_AV_DELAY_MAX;
        av_min_ms      = RST_AV_DELAY_MIN;
        model_mode     = MODE_NORMAL;
        ventricle_due  = 1'b0;
        atrial_ms      = '0;
        ventricular_ms = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table at the reset settings.
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            send_event(directed_rows[row].op, directed_rows[row].req,
                       directed_rows[row].typed, directed_rows[row].want);
        end
        wait_results_drained();

        // Short intervals, no idling: paces on nearly every cycle of the rhythm.
        load_intervals(13'd40, 13'd25, 13'd12, 13'd20, 13'd10, 13'd1, 13'd8, 13'd3);
        run_random_events(300, 70);
        wait_results_drained();

        // Extreme intervals, a masked delay write and writes to spare indexes.
        send_idle_pct = 67;
        load_intervals(13'd8191, 13'd1, 13'd600, 13'd8191, 13'd1, 13'd343,
                       13'h1FFF, 13'h1C00);
        write_reg(CFG_UNUSED_LOW, CFG_DATA_BITS'($urandom_range(8191)));
        write_reg(CFG_UNUSED_HIGH, 13'h1FFF);
        run_random_events(200, 70);
        wait_results_drained();

        // Intervals just above the refractory window, so senses get accepted.
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        load_intervals(13'd530, 13'd545, 13'd520, 13'd505, 13'd700, 13'd510,
                       13'd40, 13'd10);
        run_random_events(350, 92);
        wait_results_drained();

        // Random intervals with the longest minimum delay, both sides idling.
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        load_random_intervals();
        write_reg(CFG_AV_DELAY_MIN, {3'b011, 10'h3FF});
        run_random_events(250, 75);
        wait_results_drained();

        // Back-pressure: long receiver holds while the sender keeps offering.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_random_intervals();
        hold_requests++;
        run_random_events(40, 70);
        wait_results_drained();
        hold_requests++;
        run_random_events(40, 70);
        wait_results_drained();
        run_random_events(20, 70);
        wait_results_drained();

        // A run of ticks in manual mode, then pacing resumes.
        recv_stall_pct = 24;
        send_event(OP_MODE_REQ, MODE_MANUAL, 1'b0, '0);
        repeat (MANUAL_TICKS) send_event(OP_TICK, 2'($urandom_range(3)), 1'b0, '0);
        send_event(OP_MODE_REQ, MODE_NORMAL, 1'b0, '0);
        run_random_events(80, 70);

        // Drain with a bound, then let the pipeline settle.
        i_in_valid <= 1'b0;
        drain_cycles = 0;
        while (pace_results_due.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        if (pace_results_due.size() != 0)
            report_mismatch("results never delivered", 2'b0, 2'b0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS dual_chamber_pacing_timer");
        end else begin
            $display("FAIL dual_chamber_pacing_timer");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL dual_chamber_pacing_timer");
        $finish;
    end

endmodule

### sim.f
sv/dcpt_pkg.sv
sv/dcpt_cfg_regs.sv
sv/dcpt_core.sv
sv/dcpt_out_buf.sv
sv/dual_chamber_pacing_timer.sv
bench/dual_chamber_pacing_timer_tb.sv
